### rtl/ptf_pkg.sv
package ptf_pkg;

  // Field widths of one pixel.
  localparam int ChanW  = 8;
  localparam int PixelW = 4 * ChanW;

  // Configuration port geometry.
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 14;

  // Gain register and the per-channel multiplier built from it.
  localparam int GainW = 14;
  localparam int MultW = 18;
  localparam int ProdW = MultW + ChanW + 1;
  localparam int ScaleShift = 16;
  localparam logic signed [GainW-1:0] GainMax = 14'sd4096;
  localparam logic signed [GainW-1:0] GainMin = -14'sd4096;
  localparam logic signed [MultW-1:0] MultBase = 18'sd65535;

  // Floor division by three of a channel sum (at most 765) as a reciprocal
  // multiply: (sum * 683) >> 11 is exact over that range.
  localparam int SumW = ChanW + 2;
  localparam logic [SumW-1:0] AvgRecip = 10'd683;
  localparam int AvgShift = 11;

  localparam int ThreshW = 9;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    REG_RED_GAIN    = 3'd0,
    REG_GREEN_GAIN  = 3'd1,
    REG_BLUE_GAIN   = 3'd2,
    REG_GRAY_MODE   = 3'd3,
    REG_BOOST       = 3'd4,
    REG_CHROMA_THR  = 3'd5
  } reg_index_t;

  // Gray step codes.
  localparam logic [1:0] GRAY_NONE = 2'd0;
  localparam logic [1:0] GRAY_MAX  = 2'd1;
  localparam logic [1:0] GRAY_AVG  = 2'd2;

  // Saturate a raw 14-bit gain write to the legal range and turn it into
  // the multiplier 65535 + 16 * gain.
  function automatic logic signed [MultW-1:0] gain_to_mult(
      input logic signed [GainW-1:0] raw);
    logic signed [GainW-1:0] g;
    begin
      g = raw;
      if (raw > GainMax) g = GainMax;
      if (raw < GainMin) g = GainMin;
      gain_to_mult = MultBase + (MultW'(g) <<< 4);
    end
  endfunction

endpackage

### rtl/pixel_tint_filter_core.sv
// Pixel tint filter: recolors one ARGB8888 pixel per item. The block takes
// one item in every clock cycle while the output register is empty or its
// item is taken, and passes it through the input register, min/max/sum stage,
// gray and boost stage, multiply stage and shift-and-clamp output register;
// the whole pipeline advances together and holds while the output item is
// not taken. Pixels pass unchanged when every transform register is zero or
// when a nonzero chroma threshold exceeds the channel spread. Otherwise an
// optional gray step, an optional alpha boost and a per-channel gain of
// (65535 + 16*gain) / 65536 are applied, floored and clamped to 0..255.
// Alpha always passes through. Write registers only while no item is in
// flight; gain writes saturate to -4096..4096.
module pixel_tint_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ptf_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [ptf_pkg::CfgDataW-1:0]        cfg_data,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ptf_pkg::PixelW-1:0]          s_tdata,  // alpha_in, red_in, green_in, blue_in
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ptf_pkg::PixelW-1:0]          m_tdata   // alpha_out, red_out, green_out, blue_out
);

  localparam int CW = ptf_pkg::ChanW;

  typedef logic [CW-1:0] chan_t;
  typedef logic signed [ptf_pkg::MultW-1:0] mult_t;
  typedef logic signed [ptf_pkg::ProdW-1:0] prod_t;

  // Configuration registers.
  mult_t                      mult [3];
  logic [1:0]                 gray_mode;
  logic                       boost_enable;
  logic [ptf_pkg::ThreshW-1:0] chroma_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult[0]          <= ptf_pkg::MultBase;
      mult[1]          <= ptf_pkg::MultBase;
      mult[2]          <= ptf_pkg::MultBase;
      gray_mode        <= ptf_pkg::GRAY_NONE;
      boost_enable     <= 1'b0;
      chroma_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptf_pkg::REG_RED_GAIN:   mult[0] <= ptf_pkg::gain_to_mult(cfg_data);
        ptf_pkg::REG_GREEN_GAIN: mult[1] <= ptf_pkg::gain_to_mult(cfg_data);
        ptf_pkg::REG_BLUE_GAIN:  mult[2] <= ptf_pkg::gain_to_mult(cfg_data);
        ptf_pkg::REG_GRAY_MODE:  gray_mode <= cfg_data[1:0];
        ptf_pkg::REG_BOOST:      boost_enable <= cfg_data[0];
        ptf_pkg::REG_CHROMA_THR: chroma_threshold <= cfg_data[ptf_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  // All transform registers at zero means every item passes unchanged.
  logic all_off;
  assign all_off = (mult[0] == ptf_pkg::MultBase) && (mult[1] == ptf_pkg::MultBase) &&
                   (mult[2] == ptf_pkg::MultBase) && (gray_mode == ptf_pkg::GRAY_NONE) &&
                   !boost_enable;

  // The pipeline moves as one while the output register is free or drained.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Valid bits of the stages.
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  // Stage 1: input register.
  chan_t a1;
  chan_t c1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= s_tdata[CW-1:0];
      c1[0] <= s_tdata[2*CW-1:CW];
      c1[1] <= s_tdata[3*CW-1:2*CW];
      c1[2] <= s_tdata[4*CW-1:3*CW];
    end
  end

  // Stage 2: channel maximum, minimum and sum.
  chan_t mx_c, mn_c;
  always_comb begin
    mx_c = c1[0];
    mn_c = c1[0];
    for (int i = 1; i < 3; i++) begin
      if (c1[i] > mx_c) mx_c = c1[i];
      if (c1[i] < mn_c) mn_c = c1[i];
    end
  end

  chan_t a2, mx2, mn2;
  chan_t c2 [3];
  logic [ptf_pkg::SumW-1:0] sum2;

  always_ff @(posedge clk) begin
    if (adv) begin
      a2   <= a1;
      c2   <= c1;
      mx2  <= mx_c;
      mn2  <= mn_c;
      sum2 <= ptf_pkg::SumW'(c1[0]) + ptf_pkg::SumW'(c1[1]) + ptf_pkg::SumW'(c1[2]);
    end
  end

  // Stage 3: pass decision, gray step and boost.
  logic [2*ptf_pkg::SumW-1:0] avg_prod;
  chan_t avg_c;
  chan_t spread_c;
  logic  pass_c;
  chan_t gray_c [3];
  chan_t work_c [3];

  assign avg_prod = {{ptf_pkg::SumW{1'b0}}, sum2} *
                    {{ptf_pkg::SumW{1'b0}}, ptf_pkg::AvgRecip};
  assign avg_c    = avg_prod[ptf_pkg::AvgShift +: CW];
  assign spread_c = mx2 - mn2;
  assign pass_c   = all_off ||
                    ((chroma_threshold != '0) &&
                     ({1'b0, spread_c} < chroma_threshold));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (gray_mode)
        ptf_pkg::GRAY_MAX: gray_c[i] = mx2;
        ptf_pkg::GRAY_AVG: gray_c[i] = avg_c;
        default:           gray_c[i] = c2[i];
      endcase
      // Both halves are at most 127, so the boosted sum stays within 255.
      work_c[i] = boost_enable ? ((gray_c[i] >> 1) + (a2 >> 1)) : gray_c[i];
    end
  end

  chan_t a3;
  chan_t orig3 [3];
  chan_t c3 [3];
  logic  pass3;

  always_ff @(posedge clk) begin
    if (adv) begin
      a3    <= a2;
      orig3 <= c2;
      c3    <= work_c;
      pass3 <= pass_c;
    end
  end

  // Stage 4: gain multiply per channel.
  chan_t a4;
  chan_t orig4 [3];
  prod_t p4 [3];
  logic  pass4;

  always_ff @(posedge clk) begin
    if (adv) begin
      a4    <= a3;
      orig4 <= orig3;
      pass4 <= pass3;
      for (int i = 0; i < 3; i++) begin
        p4[i] <= prod_t'($signed({1'b0, c3[i]})) * prod_t'(mult[i]);
      end
    end
  end

  // Stage 5: floor shift, clamp and the output register.
  logic signed [ptf_pkg::ProdW-ptf_pkg::ScaleShift-1:0] q_c [3];
  chan_t res_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_c[i] = p4[i][ptf_pkg::ProdW-1:ptf_pkg::ScaleShift];
      if (q_c[i][ptf_pkg::ProdW-ptf_pkg::ScaleShift-1]) begin
        res_c[i] = '0;
      end else if (q_c[i] > $signed({3'b000, {CW{1'b1}}})) begin
        res_c[i] = '1;
      end else begin
        res_c[i] = q_c[i][CW-1:0];
      end
      if (pass4) res_c[i] = orig4[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {res_c[2], res_c[1], res_c[0], a4};
    end
  end

endmodule

### test/tb_pixel_tint_filter_core.sv
module tb_pixel_tint_filter_core;

  // One ARGB pixel, packed so that alpha sits in the lowest byte of tdata.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  // Raw data words for the six registers, in index order.
  typedef logic [ptf_pkg::CfgDataW-1:0] cfg_word_t;
  typedef cfg_word_t reg_words_t [6];

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [ptf_pkg::CfgIndexW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ptf_pkg::CfgIndexW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [ptf_pkg::CfgIndexW-1:0] REG_ORDER [6] = '{ptf_pkg::REG_RED_GAIN,
      ptf_pkg::REG_GREEN_GAIN, ptf_pkg::REG_BLUE_GAIN, ptf_pkg::REG_GRAY_MODE,
      ptf_pkg::REG_BOOST, ptf_pkg::REG_CHROMA_THR};

  localparam int IdlePct     = 22;
  localparam int HoldCycles  = 60;
  localparam int StallLimit  = 3000;
  localparam int RandPhases  = 20;
  localparam int PhaseItems  = 92;

  // Tint predictor with its own copy of the registers, plus the queue of
  // pixels still owed by the block.
  class tint_scoreboard;
    int gain [3];
    int gray_sel;
    int boost_on;
    int spread_min;
    pixel_t owed_q [$];
    int errors;
    int checked;

    function new();
      gain = '{0, 0, 0};
      gray_sel = 0;
      boost_on = 0;
      spread_min = 0;
      errors = 0;
      checked = 0;
    endfunction

    // Mirror one register write, including gain saturation.
    function void set_reg(logic [ptf_pkg::CfgIndexW-1:0] idx, cfg_word_t val);
      int g;
      g = int'($signed(val[ptf_pkg::GainW-1:0]));
      if (g > 4096) g = 4096;
      if (g < -4096) g = -4096;
      case (idx)
        ptf_pkg::REG_RED_GAIN:   gain[0] = g;
        ptf_pkg::REG_GREEN_GAIN: gain[1] = g;
        ptf_pkg::REG_BLUE_GAIN:  gain[2] = g;
        ptf_pkg::REG_GRAY_MODE:  gray_sel = int'(val[1:0]);
        ptf_pkg::REG_BOOST:      boost_on = int'(val[0]);
        ptf_pkg::REG_CHROMA_THR: spread_min = int'(val[ptf_pkg::ThreshW-1:0]);
        default: ;
      endcase
    endfunction

    // Multiply by (65535 + 16*gain) / 65536 with floor, then clamp.
    function int scale_chan(int c, int g);
      longint prod;
      prod = longint'(c) * (longint'(65535) + 16 * longint'(g));
      prod = prod >>> 16;
      if (prod < 0) prod = 0;
      if (prod > 255) prod = 255;
      return int'(prod);
    endfunction

    function pixel_t tint(pixel_t px);
      int ch [3];
      int mx, mn, a, v;
      bit keep;
      pixel_t res;
      a = int'(px.alpha);
      ch[0] = int'(px.red);
      ch[1] = int'(px.green);
      ch[2] = int'(px.blue);
      keep = gain[0] == 0 && gain[1] == 0 && gain[2] == 0 &&
             gray_sel == 0 && boost_on == 0;
      if (!keep) begin
        mx = ch[0];
        mn = ch[0];
        for (int i = 1; i < 3; i++) begin
          if (ch[i] > mx) mx = ch[i];
          if (ch[i] < mn) mn = ch[i];
        end
        if (spread_min > 0 && (mx - mn) < spread_min) keep = 1'b1;
      end
      if (!keep) begin
        if (gray_sel == int'(ptf_pkg::GRAY_MAX)) begin
          ch = '{mx, mx, mx};
        end else if (gray_sel == int'(ptf_pkg::GRAY_AVG)) begin
          v = (ch[0] + ch[1] + ch[2]) / 3;
          ch = '{v, v, v};
        end
        if (boost_on != 0) begin
          for (int i = 0; i < 3; i++) begin
            v = (ch[i] >> 1) + (a >> 1);
            ch[i] = (v > 255) ? 255 : v;
          end
        end
        for (int i = 0; i < 3; i++) ch[i] = scale_chan(ch[i], gain[i]);
      end
      res.alpha = a[7:0];
      res.red = ch[0][7:0];
      res.green = ch[1][7:0];
      res.blue = ch[2][7:0];
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      owed_q.push_back(tint(px));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Print one line per mismatch and count it.
    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected output item %h", got));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.alpha !== want.alpha)
        report($sformatf("alpha got %0d want %0d", got.alpha, want.alpha));
      if (got.red !== want.red)
        report($sformatf("red got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d want %0d", got.blue, want.blue));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ptf_pkg::CfgIndexW-1:0] cfg_index;
  logic [ptf_pkg::CfgDataW-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [ptf_pkg::PixelW-1:0] s_tdata;   // alpha_in, red_in, green_in, blue_in
  logic m_tvalid;
  logic m_tready;
  logic [ptf_pkg::PixelW-1:0] m_tdata;   // alpha_out, red_out, green_out, blue_out

  tint_scoreboard sb;
  bit calm;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int idle_cycles = 0;
  int settings_run;

  pixel_tint_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock with a 10 unit period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic pixel_t make_px(int a, int r, int g, int b);
    pixel_t px;
    px.alpha = a[7:0];
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    return px;
  endfunction

  // Mostly random pixels, some close to gray to sit near the threshold.
  function automatic pixel_t rand_px();
    int base;
    int up;
    int down;
    pixel_t px;
    if ($urandom_range(0, 3) != 0) begin
      px = pixel_t'($urandom());
    end else begin
      base = int'($urandom_range(0, 255));
      up = base + int'($urandom_range(0, 12));
      down = base - int'($urandom_range(0, 12));
      if (up > 255) up = 255;
      if (down < 0) down = 0;
      px = make_px(int'($urandom_range(0, 255)), base, up, down);
    end
    return px;
  endfunction

  function automatic cfg_word_t rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 14'sd4096;
      2: return -14'sd4096;
      3: return cfg_word_t'(int'($urandom_range(0, 8192)) - 4096);
      4: return cfg_word_t'($urandom_range(0, 16383));
      default: return cfg_word_t'(int'($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  function automatic reg_words_t rand_words(bit identity);
    reg_words_t w;
    int junk;
    junk = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16383)) : 0;
    for (int i = 0; i < 3; i++) w[i] = identity ? '0 : rand_gain();
    w[3] = identity ? '0 : cfg_word_t'((junk & ~32'h3) | $urandom_range(0, 3));
    w[4] = identity ? '0 : cfg_word_t'((junk & ~32'h1) | $urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1:    w[5] = cfg_word_t'(junk & ~32'h1FF);
      2:       w[5] = cfg_word_t'((junk & ~32'h1FF) | $urandom_range(1, 64));
      3:       w[5] = 14'd256;
      4:       w[5] = 14'd511;
      default: w[5] = cfg_word_t'((junk & ~32'h1FF) | $urandom_range(0, 511));
    endcase
    return w;
  endfunction

  // Write all six registers on back-to-back cycles, optionally followed by
  // writes to the unused indexes.
  task automatic apply_config(reg_words_t w, bit spare);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= w[i];
      sb.set_reg(REG_ORDER[i], w[i]);
      @(negedge clk);
    end
    if (spare) begin
      cfg_index <= REG_SPARE_LO;
      cfg_data <= 14'h1555;
      @(negedge clk);
      cfg_index <= REG_SPARE_HI;
      cfg_data <= 14'h2AAA;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Offer one pixel, with random gaps, and wait until it is taken.
  task automatic send_pixel(pixel_t px);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty before touching registers.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: random back-pressure plus one long hold on request.
  initial begin
    m_tready = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata);
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Stalled for %0d cycles with %0d pixels owed.", idle_cycles, sb.pending());
      $display("tb_pixel_tint_filter_core: FAIL");
      $finish;
    end
  end

  // Stimulus: reset, directed pixels under a few settings, then random phases.
  initial begin
    pixel_t dir_px [6];
    reg_words_t w;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    settings_run = 1;
    dir_px = '{make_px(0, 0, 0, 0), make_px(255, 255, 255, 255),
               make_px(255, 255, 0, 0), make_px(0, 0, 255, 128),
               make_px(128, 10, 12, 11), make_px(1, 254, 1, 127)};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings pass every pixel through.
    foreach (dir_px[i]) send_pixel(dir_px[i]);
    drain();

    // Extreme gains with gray by maximum.
    w = '{14'sd4096, -14'sd4096, 14'd0, cfg_word_t'(ptf_pkg::GRAY_MAX), 14'd0, 14'd0};
    apply_config(w, 1'b0);
    foreach (dir_px[i]) send_pixel(dir_px[i]);
    drain();

    // Out-of-range gain writes saturate; gray by average with boost.
    w = '{14'h1FFF, 14'h2000, 14'h3FFF, cfg_word_t'(ptf_pkg::GRAY_AVG), 14'd1, 14'd0};
    apply_config(w, 1'b0);
    foreach (dir_px[i]) send_pixel(dir_px[i]);
    drain();

    // Gray mode three, small threshold, and writes to unused indexes.
    w = '{14'd1, 14'h3FFF, 14'sd4096, 14'd3, 14'd1, 14'd3};
    apply_config(w, 1'b1);
    foreach (dir_px[i]) send_pixel(dir_px[i]);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      w = rand_words(ph % 5 == 4);
      apply_config(w, ph % 7 == 2);
      calm = (ph == 6);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) send_pixel(rand_px());
      drain();
    end
    calm = 1'b0;

    $display("Checked %0d pixels over %0d register settings, with random stalls",
             sb.checked, settings_run);
    $display("on both sides and one long output hold that backed up the input.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_pixel_tint_filter_core: PASS");
    end else begin
      $display("Mismatches: %0d, pixels still owed: %0d", sb.errors, sb.pending());
      $display("tb_pixel_tint_filter_core: FAIL");
    end
    $finish;
  end

endmodule

### pixel_tint_filter_core.f
rtl/ptf_pkg.sv
rtl/pixel_tint_filter_core.sv
test/tb_pixel_tint_filter_core.sv
